// ===== hdl/wpp_pkg.sv =====
`default_nettype none

package wpp_pkg;

   // Field widths
   localparam int POS_W     = 20;
   localparam int HEAD_W    = 16;
   localparam int GTOL_W    = 16;
   localparam int HTOL_W    = 15;
   localparam int SPEED_W   = 15;
   localparam int ANG_W     = 16;
   localparam int CSR_W     = 16;
   localparam int REQ_W     = 4 * POS_W + HEAD_W;
   localparam int RSP_W     = SPEED_W + ANG_W + 1;

   // Datapath widths
   localparam int DIFF_W    = POS_W + 1;
   localparam int SQ_W      = 2 * DIFF_W - 1;
   localparam int DIST_W    = SQ_W + 1;
   localparam int TOL2_W    = 2 * GTOL_W;
   localparam int PRESCALE_SH = 16;
   localparam int XY_W      = 40;
   localparam int Z_W       = 34;
   localparam int ROUND_SH  = 17;
   localparam int BEAR_W    = Z_W - ROUND_SH;
   localparam int ERR_W     = 18;

   // CORDIC setup
   localparam int ATAN_ITERATIONS  = 16;
   localparam int CORDIC_TABLE_LEN = 24;
   localparam int CORDIC_N = (ATAN_ITERATIONS > CORDIC_TABLE_LEN) ?
                             CORDIC_TABLE_LEN : ATAN_ITERATIONS;

   // atan(2^-i) in Q30, truncated
   localparam logic signed [Z_W-1:0] ATAN_TABLE [CORDIC_TABLE_LEN] = '{
      34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6,
      34'sh03FEAB76, 34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55,
      34'sh003FFFEA, 34'sh001FFFFD, 34'sh000FFFFF, 34'sh0007FFFF,
      34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF, 34'sh00007FFF,
      34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
      34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F
   };

   localparam logic signed [Z_W-1:0]   HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [Z_W-1:0]   ROUND_HALF  = 34'sd65536;
   localparam logic signed [ERR_W-1:0] PI_Q13      = 18'sd25736;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q13  = 18'sd51472;

   // Register reset values
   localparam logic [GTOL_W-1:0]  GOAL_TOL_RST  = 16'd154;
   localparam logic [HTOL_W-1:0]  HEAD_TOL_RST  = 15'd2048;
   localparam logic [SPEED_W-1:0] FWD_SPEED_RST = 15'd256;
   localparam logic [SPEED_W-1:0] TURN_SPEED_RST = 15'd410;

   typedef enum logic [1:0] {
      CSR_GOAL_TOL   = 2'd0,
      CSR_HEAD_TOL   = 2'd1,
      CSR_FWD_SPEED  = 2'd2,
      CSR_TURN_SPEED = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

// ===== hdl/waypoint_heading_pursuit.sv =====
`default_nettype none

// Channel   Direction  Payload (lowest bits first)
// req_      in         pos_x[19:0] pos_y[39:20] heading[55:40] goal_x[75:56] goal_y[95:76]
// rsp_      out        linear_speed[14:0] angular_speed[30:15] arrived[31]
// csr_      in         write enable, register index, 16-bit write data
//
// One pose is taken per cycle while the output is not stalled. Each pose passes
// through one register for the differences, one for prescale and squares,
// one per CORDIC iteration, one for the heading error and one for the command.
// Reset is synchronous and clears the valid bits; the CSRs take their reset values.
// A stalled result freezes the whole pipeline; req_tready follows that.
module waypoint_heading_pursuit (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [wpp_pkg::REQ_W-1:0]      req_tdata,   // pos_x, pos_y, heading, goal_x, goal_y
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [wpp_pkg::RSP_W-1:0]      rsp_tdata,   // linear_speed, angular_speed, arrived
   input  wire                            csr_wen,
   input  wire  wpp_pkg::csr_index_type   csr_index,
   input  wire  [wpp_pkg::CSR_W-1:0]      csr_wdata
);
   import wpp_pkg::*;

   localparam int N = CORDIC_N;

   // Configuration registers
   logic [GTOL_W-1:0]  goal_tol_ff;
   logic [HTOL_W-1:0]  head_tol_ff;
   logic [SPEED_W-1:0] fwd_speed_ff;
   logic [SPEED_W-1:0] turn_speed_ff;
   logic [TOL2_W-1:0]  tol2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_tol_ff   <= GOAL_TOL_RST;
         head_tol_ff   <= HEAD_TOL_RST;
         fwd_speed_ff  <= FWD_SPEED_RST;
         turn_speed_ff <= TURN_SPEED_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_GOAL_TOL:   goal_tol_ff   <= csr_wdata[GTOL_W-1:0];
            CSR_HEAD_TOL:   head_tol_ff   <= csr_wdata[HTOL_W-1:0];
            CSR_FWD_SPEED:  fwd_speed_ff  <= csr_wdata[SPEED_W-1:0];
            CSR_TURN_SPEED: turn_speed_ff <= csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // Squared arrival radius, registered; users change it only while idle, not enforced here
   always_ff @(posedge clock) begin
      tol2_ff <= TOL2_W'(goal_tol_ff) * TOL2_W'(goal_tol_ff);
   end

   // Whole pipeline advances unless the output holds a result not taken
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Unpack input fields
   logic signed [POS_W-1:0]  pos_x, pos_y, goal_x, goal_y;
   logic signed [HEAD_W-1:0] heading;
   assign pos_x   = req_tdata[POS_W-1:0];
   assign pos_y   = req_tdata[2*POS_W-1:POS_W];
   assign heading = req_tdata[2*POS_W+HEAD_W-1:2*POS_W];
   assign goal_x  = req_tdata[3*POS_W+HEAD_W-1:2*POS_W+HEAD_W];
   assign goal_y  = req_tdata[4*POS_W+HEAD_W-1:3*POS_W+HEAD_W];

   // Stage D: position differences
   logic                     d_valid_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [HEAD_W-1:0] d_head_ff;

   assign dx_in = DIFF_W'(goal_x) - DIFF_W'(pos_x);
   assign dy_in = DIFF_W'(goal_y) - DIFF_W'(pos_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         d_head_ff <= heading;
      end
   end

   // Stage C0: prescale, quadrant pre-rotation, squares
   logic signed [XY_W-1:0]   x_ff [0:N];
   logic signed [XY_W-1:0]   y_ff [0:N];
   logic signed [Z_W-1:0]    z_ff [0:N];
   logic                     v_ff [0:N];
   logic                     zero_ff [0:N];
   logic                     far_ff [0:N];
   logic signed [HEAD_W-1:0] hd_ff [0:N];
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;

   logic signed [XY_W-1:0]     dxs, dys, x0_in, y0_in;
   logic signed [Z_W-1:0]      z0_in;
   logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;

   assign dxs = {{(XY_W-DIFF_W-PRESCALE_SH){dx_ff[DIFF_W-1]}}, dx_ff, {PRESCALE_SH{1'b0}}};
   assign dys = {{(XY_W-DIFF_W-PRESCALE_SH){dy_ff[DIFF_W-1]}}, dy_ff, {PRESCALE_SH{1'b0}}};
   assign sqx_full = dx_ff * dx_ff;
   assign sqy_full = dy_ff * dy_ff;

   // Rotate a left-half vector by a quarter turn into the right half
   always_comb begin
      x0_in = dxs;
      y0_in = dys;
      z0_in = '0;
      if (dx_ff[DIFF_W-1]) begin
         if (!dy_ff[DIFF_W-1]) begin
            x0_in = dys;
            y0_in = -dxs;
            z0_in = HALF_PI_Q30;
         end else begin
            x0_in = -dys;
            y0_in = dxs;
            z0_in = -HALF_PI_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (dx_ff == '0) && (dy_ff == '0);
         far_ff[0]  <= 1'b0;
         hd_ff[0]   <= d_head_ff;
         sqx_ff     <= sqx_full[SQ_W-1:0];
         sqy_ff     <= sqy_full[SQ_W-1:0];
      end
   end

   // Squared distance against squared radius, taken with the first iteration
   logic [DIST_W-1:0] dist2;
   logic              far_in;
   assign dist2  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign far_in = dist2 > DIST_W'(tol2_ff);

   // CORDIC vectoring iterations, one stage each
   for (genvar k = 0; k < N; k++) begin : g_iter
      logic signed [XY_W-1:0] xs, ys, x_in, y_in;
      logic signed [Z_W-1:0]  z_in;
      logic                   y_pos;

      assign xs    = x_ff[k] >>> k;
      assign ys    = y_ff[k] >>> k;
      assign y_pos = !y_ff[k][XY_W-1] && (y_ff[k] != '0);

      always_comb begin
         if (y_pos) begin
            x_in = x_ff[k] + ys;
            y_in = y_ff[k] - xs;
            z_in = z_ff[k] + ATAN_TABLE[k];
         end else begin
            x_in = x_ff[k] - ys;
            y_in = y_ff[k] + xs;
            z_in = z_ff[k] - ATAN_TABLE[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (advance) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            z_ff[k+1]    <= z_in;
            zero_ff[k+1] <= zero_ff[k];
            far_ff[k+1]  <= (k == 0) ? far_in : far_ff[k];
            hd_ff[k+1]   <= hd_ff[k];
         end
      end
   end

   // Stage E: round the bearing to Q3.13 and subtract the heading
   logic                    e_valid_ff, e_far_ff;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [Z_W-1:0]   z_round;
   logic signed [BEAR_W-1:0] bearing;

   assign z_round = z_ff[N] + ROUND_HALF;
   assign bearing = zero_ff[N] ? '0 : z_round[Z_W-1:ROUND_SH];
   assign err_in  = ERR_W'(bearing) - ERR_W'(hd_ff[N]);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= v_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err_ff   <= err_in;
         e_far_ff <= far_ff[N];
      end
   end

   // Stage F: wrap once, then pick turn, drive or stop
   logic signed [ERR_W-1:0] err_w, aerr;
   logic [SPEED_W-1:0]      lin_in, lin_ff;
   logic [ANG_W-1:0]        ang_in, ang_ff;
   logic                    arr_in, arr_ff, out_valid_ff;

   always_comb begin
      priority if (err_ff > PI_Q13) begin
         err_w = err_ff - TWO_PI_Q13;
      end else if (err_ff < -PI_Q13) begin
         err_w = err_ff + TWO_PI_Q13;
      end else begin
         err_w = err_ff;
      end
   end

   assign aerr = err_w[ERR_W-1] ? -err_w : err_w;

   always_comb begin
      lin_in = '0;
      ang_in = '0;
      arr_in = 1'b0;
      priority if (aerr > $signed({{(ERR_W-HTOL_W){1'b0}}, head_tol_ff})) begin
         ang_in = err_w[ERR_W-1] ? -ANG_W'(turn_speed_ff) : ANG_W'(turn_speed_ff);
      end else if (e_far_ff) begin
         lin_in = fwd_speed_ff;
      end else begin
         arr_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lin_ff <= lin_in;
         ang_ff <= ang_in;
         arr_ff <= arr_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {arr_ff, ang_ff, lin_ff};

endmodule

`default_nettype wire

// ===== hdl/wpp_checker.sv =====
`default_nettype none

module wpp_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_tready,
   input wire                          rsp_tvalid,
   input wire                          rsp_tready,
   input wire [wpp_pkg::RSP_W-1:0]     rsp_tdata
);
   import wpp_pkg::*;

   logic [SPEED_W-1:0] lin;
   logic [ANG_W-1:0]   ang;
   logic               arr;
   assign lin = rsp_tdata[SPEED_W-1:0];
   assign ang = rsp_tdata[SPEED_W+ANG_W-1:SPEED_W];
   assign arr = rsp_tdata[RSP_W-1];

   // A result not taken stays and holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Input is refused only when the output is stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input refused without output stall");

   // Arrival means zero speeds; never drive and turn at once
   a_arrived: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && arr |-> lin == '0 && ang == '0)
      else $error("arrived with nonzero speed");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> lin == '0 || ang == '0)
      else $error("drive and turn commanded together");

   // Reset flushes the pipeline
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind waypoint_heading_pursuit wpp_checker u_wpp_checker (.*);

`default_nettype wire

// ===== test/tb_waypoint_heading_pursuit.sv =====
module tb_waypoint_heading_pursuit;
   import wpp_pkg::*;

   localparam int     PIPE_LATENCY   = ATAN_ITERATIONS + 4;
   localparam int     STEP_COUNT     = (ATAN_ITERATIONS > 24) ? 24 : ATAN_ITERATIONS;
   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     HOLD_CYCLES    = 300;
   localparam int     PHASES         = 10;
   localparam int     POSES_PER_SET  = 50;
   localparam int     N_DIRECTED     = 21;
   localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
   localparam longint HALF_TURN_Q13    = 64'sd25736;
   localparam longint FULL_TURN_Q13    = 64'sd51472;

   // atan(2^-i) in Q30, truncated
   localparam longint ARCTAN_STEPS [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
   };

   typedef struct packed {
      logic signed [19:0] goal_y;
      logic signed [19:0] goal_x;
      logic signed [15:0] heading;
      logic signed [19:0] pos_y;
      logic signed [19:0] pos_x;
   } pose_type;

   typedef struct packed {
      logic               arrived;
      logic signed [15:0] angular_speed;
      logic        [14:0] linear_speed;
   } cmd_type;

   typedef struct {
      pose_type pose;
      bit       fixed;
      cmd_type  want;
   } directed_row_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata  = '0;   // pos_x, pos_y, heading, goal_x, goal_y
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;         // linear_speed, angular_speed, arrived
   logic                csr_wen    = 1'b0;
   csr_index_type       csr_index  = CSR_GOAL_TOL;
   logic [CSR_W-1:0]    csr_wdata  = '0;

   // Register copy used for prediction
   logic [15:0] goal_radius    = GOAL_TOL_RST;
   logic [14:0] heading_margin = HEAD_TOL_RST;
   logic [14:0] drive_speed    = FWD_SPEED_RST;
   logic [14:0] turn_rate      = TURN_SPEED_RST;

   cmd_type pending_commands [$];
   int   poses_sent     = 0;
   int   results_seen   = 0;
   int   turns_seen     = 0;
   int   drives_seen    = 0;
   int   arrivals_seen  = 0;
   int   mismatches     = 0;
   int   settings_used  = 1;
   int   idle_cycles    = 0;
   bit   gaps_on        = 1'b1;
   bit   hold_rsp       = 1'b0;

   waypoint_heading_pursuit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Bearing of (dx, dy) in Q3.13 by vectoring CORDIC
   function automatic longint bearing_q13(longint dx, longint dy);
      longint x, y, z, xs, ys, t;
      if (dx == 0 && dy == 0)
         return 0;
      x = dx * 65536;
      y = dy * 65536;
      z = 0;
      // pre-rotate the left half plane by a quarter turn
      if (dx < 0) begin
         t = x;
         if (dy >= 0) begin
            x = y;
            y = -t;
            z = QUARTER_TURN_Q30;
         end else begin
            x = -y;
            y = t;
            z = -QUARTER_TURN_Q30;
         end
      end
      for (int i = 0; i < STEP_COUNT; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARCTAN_STEPS[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARCTAN_STEPS[i];
         end
      end
      return (z + 65536) >>> 17;
   endfunction

   // Speed command for one pose under the current registers
   function automatic cmd_type predict_command(pose_type p);
      cmd_type c;
      longint  dx, dy, dist2, tol2, err, aerr;
      dx    = longint'(p.goal_x) - longint'(p.pos_x);
      dy    = longint'(p.goal_y) - longint'(p.pos_y);
      dist2 = dx * dx + dy * dy;
      tol2  = longint'(goal_radius) * longint'(goal_radius);
      err   = bearing_q13(dx, dy) - longint'(p.heading);
      // wrap once only
      if (err > HALF_TURN_Q13)
         err = err - FULL_TURN_Q13;
      else if (err < -HALF_TURN_Q13)
         err = err + FULL_TURN_Q13;
      aerr = (err < 0) ? -err : err;
      c = '0;
      if (aerr > longint'(heading_margin)) begin
         c.angular_speed = (err > 0) ? $signed({1'b0, turn_rate}) : -$signed({1'b0, turn_rate});
      end else if (dist2 > tol2) begin
         c.linear_speed = drive_speed;
      end else begin
         c.arrived = 1'b1;
      end
      return c;
   endfunction

   function automatic pose_type mk_pose(int px, int py, int hd, int gx, int gy);
      pose_type p;
      p.pos_x   = px[19:0];
      p.pos_y   = py[19:0];
      p.heading = hd[15:0];
      p.goal_x  = gx[19:0];
      p.goal_y  = gy[19:0];
      return p;
   endfunction

   function automatic cmd_type mk_cmd(int lin, int ang, bit arr);
      cmd_type c;
      c.linear_speed  = lin[14:0];
      c.angular_speed = ang[15:0];
      c.arrived       = arr;
      return c;
   endfunction

   function automatic logic signed [19:0] clamp_pos(longint v);
      if (v > 524287)
         return 20'sd524287;
      if (v < -524288)
         return -20'sd524288;
      return v[19:0];
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Random pose: near-goal and aligned-heading cases dominate, the rest is raw noise or an in-range heading
   function automatic pose_type random_pose();
      pose_type p;
      int       mode, span, noise;
      longint   hd;
      p    = {$urandom, $urandom, $urandom};
      mode = $urandom_range(0, 9);
      if (mode >= 2 && mode <= 5) begin
         span     = 2 * int'(goal_radius) + 8;
         p.goal_x = clamp_pos(longint'(p.pos_x) + int'($urandom_range(0, 2 * span)) - span);
         p.goal_y = clamp_pos(longint'(p.pos_y) + int'($urandom_range(0, 2 * span)) - span);
      end
      if (mode >= 2 && mode <= 7) begin
         noise = int'(heading_margin) + 64;
         hd = bearing_q13(longint'(p.goal_x) - longint'(p.pos_x),
                          longint'(p.goal_y) - longint'(p.pos_y))
              + int'($urandom_range(0, 2 * noise)) - noise;
         p.heading = hd[15:0];
      end else if (mode >= 8) begin
         hd = int'($urandom_range(0, 51472)) - 25736;
         p.heading = hd[15:0];
      end
      return p;
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t ERROR: %s", $time, msg);
      mismatches++;
   endtask

   // Offer one pose, wait for its transfer, then queue what it should produce
   task automatic offer_pose(pose_type p, bit fixed, cmd_type want, bit last);
      bit gap;
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      pending_commands.push_back(fixed ? want : predict_command(p));
      poses_sent++;
      gap = gaps_on && ($urandom_range(0, 9) < 3);
      if (gap || last)
         req_tvalid <= 1'b0;
      if (gap)
         repeat (idle_span()) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_GOAL_TOL:   goal_radius    = value[15:0];
         CSR_HEAD_TOL:   heading_margin = value[14:0];
         CSR_FWD_SPEED:  drive_speed    = value[14:0];
         CSR_TURN_SPEED: turn_rate      = value[14:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_commands.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Result side: random back-pressure, one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (idle_span()) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Check each result transfer against the oldest pending command; watch for a hang
   always @(posedge clock) begin : result_check
      cmd_type got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("waypoint_heading_pursuit: mismatch");
            $finish;
         end else if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_commands.size() == 0) begin
               report_mismatch($sformatf("result %0h with nothing pending", got));
            end else begin
               want = pending_commands.pop_front();
               results_seen++;
               if (want.arrived)
                  arrivals_seen++;
               if (want.linear_speed != 0)
                  drives_seen++;
               if (want.angular_speed != 0)
                  turns_seen++;
               if (got.linear_speed !== want.linear_speed)
                  report_mismatch($sformatf("result %0d linear_speed got %0d want %0d",
                     results_seen, got.linear_speed, want.linear_speed));
               if (got.angular_speed !== want.angular_speed)
                  report_mismatch($sformatf("result %0d angular_speed got %0d want %0d",
                     results_seen, got.angular_speed, want.angular_speed));
               if (got.arrived !== want.arrived)
                  report_mismatch($sformatf("result %0d arrived got %0b want %0b",
                     results_seen, got.arrived, want.arrived));
            end
         end
      end
   end

   initial begin : stimulus
      directed_row_type rows [N_DIRECTED];
      rows = '{
         // goal on the robot, level heading: arrived
         '{mk_pose(0, 0, 0, 0, 0),                     1'b1, mk_cmd(0, 0, 1'b1)},
         '{mk_pose(100, -100, 0, 100, -100),           1'b1, mk_cmd(0, 0, 1'b1)},
         // straight ahead: drive; left and right: turn
         '{mk_pose(0, 0, 0, 10240, 0),                 1'b1, mk_cmd(256, 0, 1'b0)},
         '{mk_pose(0, 0, 0, 0, 10240),                 1'b1, mk_cmd(0, 410, 1'b0)},
         '{mk_pose(0, 0, 0, 0, -10240),                1'b1, mk_cmd(0, -410, 1'b0)},
         // full-scale position differences
         '{mk_pose(-524288, -524288, 0, 524287, -524288), 1'b1, mk_cmd(256, 0, 1'b0)},
         '{mk_pose(524287, 524287, 0, -524288, -524288),  1'b1, mk_cmd(0, -410, 1'b0)},
         // error exactly plus or minus pi: kept, turn
         '{mk_pose(5, 5, 25736, 5, 5),                 1'b1, mk_cmd(0, -410, 1'b0)},
         '{mk_pose(5, 5, -25736, 5, 5),                1'b1, mk_cmd(0, 410, 1'b0)},
         // heading outside its range, one wrap
         '{mk_pose(0, 0, -32768, 0, 0),                1'b1, mk_cmd(0, -410, 1'b0)},
         '{mk_pose(0, 0, 32767, 0, 0),                 1'b1, mk_cmd(0, 410, 1'b0)},
         // heading error at and just past the tolerance
         '{mk_pose(7, 7, 2048, 7, 7),                  1'b1, mk_cmd(0, 0, 1'b1)},
         '{mk_pose(7, 7, -2049, 7, 7),                 1'b1, mk_cmd(0, 410, 1'b0)},
         // goal behind, bearing near pi
         '{mk_pose(0, 0, 25736, -10240, 0),            1'b0, '0},
         '{mk_pose(0, 0, -25736, -10240, 0),           1'b0, '0},
         // distance on and just past the goal radius
         '{mk_pose(0, 0, 0, 154, 0),                   1'b0, '0},
         '{mk_pose(0, 0, 0, 155, 0),                   1'b0, '0},
         '{mk_pose(-1, -1, 6434, 108, 108),            1'b0, '0},
         '{mk_pose(-524288, 524287, -25736, 524287, -524288), 1'b0, '0},
         '{mk_pose(524287, -524288, 25736, -524288, 524287),  1'b0, '0},
         '{mk_pose(-1, -1, -1, -1, -1),                1'b0, '0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed poses under the reset register values
      for (int i = 0; i < N_DIRECTED; i++)
         offer_pose(rows[i].pose, rows[i].fixed, rows[i].want, i == N_DIRECTED - 1);

      // Random poses, one register setting per phase
      for (int phase = 1; phase <= PHASES; phase++) begin
         drain();
         case (phase)
            1: begin
               write_csr(CSR_GOAL_TOL, 16'd0);
               write_csr(CSR_HEAD_TOL, 16'd0);
               write_csr(CSR_FWD_SPEED, 16'd32767);
               write_csr(CSR_TURN_SPEED, 16'd32767);
            end
            2: begin
               // all-ones data masks to the widest values; bit 15 alone masks to zero
               write_csr(CSR_GOAL_TOL, 16'hFFFF);
               write_csr(CSR_HEAD_TOL, 16'hFFFF);
               write_csr(CSR_FWD_SPEED, 16'h0000);
               write_csr(CSR_TURN_SPEED, 16'h8000);
            end
            3: begin
               write_csr(CSR_GOAL_TOL, 16'd1000);
               write_csr(CSR_HEAD_TOL, 16'd25736);
               write_csr(CSR_FWD_SPEED, 16'd1);
               write_csr(CSR_TURN_SPEED, 16'd1);
            end
            4: begin
               write_csr(CSR_GOAL_TOL, 16'd300);
               write_csr(CSR_HEAD_TOL, 16'd100);
               write_csr(CSR_FWD_SPEED, 16'($urandom_range(0, 32767)));
               write_csr(CSR_TURN_SPEED, 16'd0);
            end
            default: begin
               write_csr(CSR_GOAL_TOL, 16'($urandom_range(0, 3000)));
               write_csr(CSR_HEAD_TOL, 16'($urandom_range(0, 25736)));
               write_csr(CSR_FWD_SPEED, 16'($urandom_range(0, 32767)));
               write_csr(CSR_TURN_SPEED, 16'($urandom_range(0, 32767)));
            end
         endcase
         csr_wen <= 1'b0;
         settings_used++;
         gaps_on = (phase % 4 != 3);
         // fill the pipeline against a held-off receiver
         if (phase == 6) begin
            gaps_on  = 1'b0;
            hold_rsp = 1'b1;
         end
         for (int k = 0; k < POSES_PER_SET; k++)
            offer_pose(random_pose(), 1'b0, '0, k == POSES_PER_SET - 1);
      end

      drain();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      $display("ran %0d poses under %0d register settings, %0d results checked",
               poses_sent, settings_used, results_seen);
      $display("commands seen: %0d turns, %0d drives, %0d arrivals, %0d field errors",
               turns_seen, drives_seen, arrivals_seen, mismatches);
      if (mismatches == 0 && pending_commands.size() == 0)
         $display("waypoint_heading_pursuit: match");
      else
         $display("waypoint_heading_pursuit: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/wpp_pkg.sv
hdl/waypoint_heading_pursuit.sv
hdl/wpp_checker.sv
test/tb_waypoint_heading_pursuit.sv
